// File: hdl/fetr_pkg.sv
`default_nettype none
package fetr_pkg;

    localparam int RING_DEPTH   = 64;
    localparam int RECORD_BYTES = 12;
    localparam int HDR_BYTES    = 8;

    localparam int SLOT_W     = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int STREAM_MAX = HDR_BYTES + RING_DEPTH * RECORD_BYTES;
    localparam int CUR_W      = $clog2(STREAM_MAX + 1);
    localparam int BYTE_W     = $clog2(RECORD_BYTES);
    localparam int HDR_W      = $clog2(HDR_BYTES);
    localparam int REC_W      = RECORD_BYTES * 8;

    localparam logic [1:0] OP_EVENT = 2'd0;
    localparam logic [1:0] OP_SNAP  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] tick;
        logic [7:0]  event_type;
        logic [7:0]  arg_a;
        logic [15:0] arg_b;
        logic [15:0] arg_c;
        logic [15:0] arg_d;
    } t_in_item;

    typedef struct packed {
        logic [6:0] record_count;
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       drained;
    } t_out_item;

    typedef struct packed {
        logic wr_event;
        logic snap;
        logic rd_start;
        logic rd_finish;
    } t_cmd;

endpackage
`default_nettype wire

// File: hdl/fetr_ifs.sv
`default_nettype none
interface fetr_in_if;
    import fetr_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fetr_out_if;
    import fetr_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/fetr_ram.sv
`default_nettype none
module fetr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// File: hdl/fetr_ctrl.sv
`default_nettype none
module fetr_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic [1:0]  i_op,
    input  wire logic        i_out_ready,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output fetr_pkg::t_cmd   o_cmd
);
    import fetr_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RD   = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic w_accept;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd = '0;
        if (w_accept) begin
            case (i_op)
                OP_EVENT: o_cmd.wr_event = 1'b1;
                OP_SNAP:  o_cmd.snap     = 1'b1;
                OP_READ:  o_cmd.rd_start = 1'b1;
                default:  o_cmd          = '0;
            endcase
        end
        o_cmd.rd_finish = (r_state == S_RD);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.rd_start) begin
                    n_state = S_RD;
                end
            end
            S_RD:    n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.snap || o_cmd.rd_finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule
`default_nettype wire

// File: hdl/fetr_dp.sv
`default_nettype none
module fetr_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire fetr_pkg::t_cmd      i_cmd,
    input  wire fetr_pkg::t_in_item  i_item,
    output fetr_pkg::t_out_item      o_res
);
    import fetr_pkg::*;

    localparam logic [7:0] HDR_I = 8'h49;
    localparam logic [7:0] HDR_T = 8'h54;
    localparam logic [7:0] HDR_R = 8'h52;
    localparam logic [7:0] HDR_C = 8'h43;

    logic [SLOT_W-1:0] r_head, n_head;
    logic              r_wrapped, n_wrapped;
    logic              r_frozen, n_frozen;
    logic [CNT_W-1:0]  r_snap_count, n_snap_count;
    logic [CUR_W-1:0]  r_total, n_total;
    logic [CUR_W-1:0]  r_cursor, n_cursor;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic [SLOT_W-1:0] r_slot, n_slot;

    logic              r_p_valid;
    logic              r_p_hdr;
    logic [HDR_W-1:0]  r_p_hdr_idx;
    logic [BYTE_W-1:0] r_p_byte;
    logic              r_p_done;
    t_out_item         r_res;

    logic              w_we;
    logic [REC_W-1:0]  w_wdata;
    logic [REC_W-1:0]  w_rdata;
    logic [CNT_W-1:0]  w_count;
    logic              w_avail;
    logic              w_hdr;
    logic [CUR_W-1:0]  w_cur_next;
    logic              w_done;
    logic [7:0]        w_byte_out;

    assign w_we    = i_cmd.wr_event && !r_frozen;
    assign w_wdata = REC_W'({i_item.arg_d, i_item.arg_c, i_item.arg_b,
                             i_item.arg_a, i_item.event_type, i_item.tick});
    assign w_count = r_wrapped ? CNT_W'(RING_DEPTH) : CNT_W'(r_head);

    assign w_avail    = r_cursor < r_total;
    assign w_hdr      = r_cursor < CUR_W'(HDR_BYTES);
    assign w_cur_next = w_avail ? r_cursor + CUR_W'(1) : r_cursor;
    assign w_done     = w_cur_next >= r_total;

    fetr_ram #(
        .WIDTH (REC_W),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_head),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_start),
        .i_raddr (r_slot),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_head       = r_head;
        n_wrapped    = r_wrapped;
        n_frozen     = r_frozen;
        n_snap_count = r_snap_count;
        n_total      = r_total;
        n_cursor     = r_cursor;
        n_byte       = r_byte;
        n_slot       = r_slot;
        if (w_we) begin
            if (r_head == SLOT_W'(RING_DEPTH - 1)) begin
                n_head    = '0;
                n_wrapped = 1'b1;
            end else begin
                n_head = r_head + SLOT_W'(1);
            end
        end
        if (i_cmd.snap) begin
            n_snap_count = w_count;
            n_total      = CUR_W'(HDR_BYTES) + CUR_W'(w_count) * CUR_W'(RECORD_BYTES);
            n_cursor     = '0;
            n_byte       = '0;
            n_slot       = r_wrapped ? r_head : '0;
            n_frozen     = 1'b1;
        end
        if (i_cmd.rd_start) begin
            n_cursor = w_cur_next;
            if (w_avail && !w_hdr) begin
                if (r_byte == BYTE_W'(RECORD_BYTES - 1)) begin
                    n_byte = '0;
                    n_slot = (r_slot == SLOT_W'(RING_DEPTH - 1)) ? '0 : r_slot + SLOT_W'(1);
                end else begin
                    n_byte = r_byte + BYTE_W'(1);
                end
            end
            if (w_done) begin
                n_frozen = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_wrapped    <= 1'b0;
            r_frozen     <= 1'b0;
            r_snap_count <= '0;
            r_total      <= CUR_W'(HDR_BYTES);
            r_cursor     <= '0;
            r_byte       <= '0;
            r_slot       <= '0;
        end else begin
            r_head       <= n_head;
            r_wrapped    <= n_wrapped;
            r_frozen     <= n_frozen;
            r_snap_count <= n_snap_count;
            r_total      <= n_total;
            r_cursor     <= n_cursor;
            r_byte       <= n_byte;
            r_slot       <= n_slot;
        end
    end

    // read beat context, consumed in the next cycle together with the ram data
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_start) begin
            r_p_valid   <= w_avail;
            r_p_hdr     <= w_hdr;
            r_p_hdr_idx <= r_cursor[HDR_W-1:0];
            r_p_byte    <= r_byte;
            r_p_done    <= w_done;
        end
    end

    always_comb begin
        w_byte_out = '0;
        if (r_p_valid) begin
            if (r_p_hdr) begin
                case (r_p_hdr_idx)
                    3'd0:    w_byte_out = HDR_I;
                    3'd1:    w_byte_out = HDR_T;
                    3'd2:    w_byte_out = HDR_R;
                    3'd3:    w_byte_out = HDR_C;
                    3'd4:    w_byte_out = 8'(r_snap_count);
                    3'd5:    w_byte_out = 8'(r_snap_count >> 8);
                    3'd6:    w_byte_out = 8'(RECORD_BYTES);
                    default: w_byte_out = 8'(RECORD_BYTES >> 8);
                endcase
            end else begin
                w_byte_out = w_rdata[{r_p_byte, 3'b000} +: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.snap) begin
            r_res.record_count <= 7'(w_count);
            r_res.data_byte    <= '0;
            r_res.byte_valid   <= 1'b0;
            r_res.drained      <= 1'b0;
        end else if (i_cmd.rd_finish) begin
            r_res.record_count <= 7'(r_snap_count);
            r_res.data_byte    <= w_byte_out;
            r_res.byte_valid   <= r_p_valid;
            r_res.drained      <= r_p_done;
        end
    end

    assign o_res = r_res;
endmodule
`default_nettype wire

// File: hdl/freezable_event_trace_ring.sv
// channel   modport  payload                                           beat
// i_ev      sink     op tick event_type arg_a arg_b arg_c arg_d        valid & ready
// o_res     source   record_count data_byte byte_valid drained         valid & ready
//
// a stream read takes longer than an event or a snapshot, as it goes through the
// registered read port of the record ram.
// an event gives no result, a snapshot and a read give one.
// reset clears the pointers, flags and cursor; the record ram is not cleared.
// i_ev is held off while a result waits on a stalled o_res.
`default_nettype none
module freezable_event_trace_ring (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fetr_in_if.sink    i_ev,
    fetr_out_if.source o_res
);
    import fetr_pkg::*;

    t_cmd      w_cmd;
    logic      w_in_ready;
    logic      w_out_valid;
    t_out_item w_res;

    fetr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_ev.valid),
        .i_op        (i_ev.data.op),
        .i_out_ready (o_res.ready),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    fetr_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_item  (i_ev.data),
        .o_res   (w_res)
    );

    assign i_ev.ready  = w_in_ready;
    assign o_res.valid = w_out_valid;
    assign o_res.data  = w_res;
endmodule
`default_nettype wire

// File: hdl/fetr_checker.sv
`default_nettype none
module fetr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic [1:0] i_op,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_data_byte,
    input wire logic       i_byte_valid,
    input wire logic       i_drained
);
    import fetr_pkg::*;

    logic w_in_beat;
    assign w_in_beat = i_in_valid && i_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_data_byte))
        else $error("result dropped or changed under stall");

    a_empty_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_byte_valid |-> i_data_byte == 8'd0)
        else $error("nonzero data on empty read");

    a_snap_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat && i_op == OP_SNAP |=> i_out_valid && !i_byte_valid && !i_drained)
        else $error("snapshot result missing or malformed");

    a_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat && (i_op == OP_EVENT || i_op == OP_SPARE) |=> !i_out_valid)
        else $error("result invented for event beat");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat && i_op == OP_READ |=> !i_in_ready ##1 i_out_valid)
        else $error("read beat not sequenced");
endmodule

bind freezable_event_trace_ring fetr_checker u_fetr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_ev.valid),
    .i_in_ready   (i_ev.ready),
    .i_op         (i_ev.data.op),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_data_byte  (o_res.data.data_byte),
    .i_byte_valid (o_res.data.byte_valid),
    .i_drained    (o_res.data.drained)
);
`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;
    import fetr_pkg::*;

    localparam int RANDOM_ITEMS = 1650;
    localparam int HOLD_CYCLES  = 150;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 20;

    typedef struct {
        t_in_item  beat;
        bit        typed;
        t_out_item want;
    } t_stim_row;

    logic clk;
    logic rst_n;

    fetr_in_if  ev_if ();
    fetr_out_if res_if ();

    freezable_event_trace_ring u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_ev    (ev_if),
        .o_res   (res_if)
    );

    // predicted ring state
    logic [REC_W-1:0]  trace_mem [RING_DEPTH];
    logic [SLOT_W-1:0] ring_head    = '0;
    logic              ring_wrapped = 1'b0;
    logic              ring_frozen  = 1'b0;
    logic [CNT_W-1:0]  snap_cnt     = '0;
    logic [SLOT_W-1:0] snap_old     = '0;
    logic [CUR_W-1:0]  stream_pos   = '0;

    t_out_item pending_results [$];
    t_stim_row dir_rows [$];
    int        live_items  = 0;
    int        mismatches  = 0;
    int        idle_cycles = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic [7:0] stream_byte(input int pos);
        int off;
        int slot;
        case (pos)
            0: return "I";
            1: return "T";
            2: return "R";
            3: return "C";
            4: return 8'(int'(snap_cnt));
            5: return 8'(int'(snap_cnt) >> 8);
            6: return 8'(RECORD_BYTES);
            7: return 8'(RECORD_BYTES >> 8);
            default: begin
                off  = pos - HDR_BYTES;
                slot = (int'(snap_old) + off / RECORD_BYTES) % RING_DEPTH;
                return trace_mem[slot][8 * (off % RECORD_BYTES) +: 8];
            end
        endcase
    endfunction

    function automatic bit trace_ring_step(input t_in_item b, output t_out_item r);
        int total;
        r = '0;
        case (b.op)
            OP_EVENT: begin
                if (!ring_frozen) begin
                    trace_mem[ring_head] = REC_W'({b.arg_d, b.arg_c, b.arg_b, b.arg_a,
                                                   b.event_type, b.tick});
                    if (ring_head == SLOT_W'(RING_DEPTH - 1)) begin
                        ring_head    = '0;
                        ring_wrapped = 1'b1;
                    end else begin
                        ring_head = ring_head + 1'b1;
                    end
                    live_items++;
                end
                return 1'b0;
            end
            OP_SNAP: begin
                snap_cnt       = ring_wrapped ? CNT_W'(RING_DEPTH) : CNT_W'(ring_head);
                snap_old       = ring_wrapped ? ring_head : '0;
                stream_pos     = '0;
                ring_frozen    = 1'b1;
                r.record_count = snap_cnt;
                live_items++;
                return 1'b1;
            end
            OP_READ: begin
                total = HDR_BYTES + int'(snap_cnt) * RECORD_BYTES;
                if (int'(stream_pos) < total) begin
                    r.data_byte  = stream_byte(int'(stream_pos));
                    r.byte_valid = 1'b1;
                    stream_pos   = stream_pos + 1'b1;
                end
                if (int'(stream_pos) >= total) begin
                    r.drained   = 1'b1;
                    ring_frozen = 1'b0;
                end
                r.record_count = snap_cnt;
                live_items++;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_in_item item_of(input logic [1:0] op, input logic [31:0] tick,
                                         input logic [7:0] ty, input logic [7:0] a,
                                         input logic [15:0] b, input logic [15:0] c,
                                         input logic [15:0] d);
        t_in_item it;
        it.op         = op;
        it.tick       = tick;
        it.event_type = ty;
        it.arg_a      = a;
        it.arg_b      = b;
        it.arg_c      = c;
        it.arg_d      = d;
        return it;
    endfunction

    function automatic t_in_item beat_of(input logic [1:0] op);
        return item_of(op, $urandom, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)));
    endfunction

    function automatic t_out_item result_of(input logic [6:0] cnt, input logic [7:0] data,
                                            input logic valid, input logic done);
        t_out_item r;
        r.record_count = cnt;
        r.data_byte    = data;
        r.byte_valid   = valid;
        r.drained      = done;
        return r;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat
    task automatic post_beat(input t_in_item b, input bit typed, input t_out_item want);
        int        gap;
        bit        produced;
        t_out_item got;
        gap = $urandom_range(0, 7);
        if (gap > 0) begin
            ev_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        ev_if.valid <= 1'b1;
        ev_if.data  <= b;
        do @(posedge clk); while (!(ev_if.valid && ev_if.ready));
        produced = trace_ring_step(b, got);
        if (produced)
            pending_results.push_back(typed ? want : got);
        @(negedge clk);
    endtask

    task automatic post(input t_in_item b);
        post_beat(b, 1'b0, '0);
    endtask

    task automatic read_bytes(input int n);
        repeat (n) post(beat_of(OP_READ));
    endtask

    task automatic drain_stream();
        while (ring_frozen)
            post(beat_of(OP_READ));
    endtask

    task automatic record_burst(input int n);
        repeat (n) begin
            if ($urandom_range(0, 7) == 0)
                post(beat_of(OP_SPARE));
            post(beat_of(OP_EVENT));
        end
    endtask

    initial begin
        int n;
        ev_if.valid = 1'b0;
        ev_if.data  = '0;

        // header before any snapshot, then a read past the end
        dir_rows.push_back('{beat_of(OP_READ), 1'b1, result_of(0, "I", 1, 0)});
        dir_rows.push_back('{beat_of(OP_READ), 1'b1, result_of(0, "T", 1, 0)});
        dir_rows.push_back('{beat_of(OP_READ), 1'b1, result_of(0, "R", 1, 0)});
        dir_rows.push_back('{beat_of(OP_READ), 1'b1, result_of(0, "C", 1, 0)});
        dir_rows.push_back('{beat_of(OP_READ), 1'b1, result_of(0, 0, 1, 0)});
        dir_rows.push_back('{beat_of(OP_READ), 1'b1, result_of(0, 0, 1, 0)});
        dir_rows.push_back('{beat_of(OP_READ), 1'b1, result_of(0, 8'(RECORD_BYTES), 1, 0)});
        dir_rows.push_back('{beat_of(OP_READ), 1'b1, result_of(0, 0, 1, 1)});
        dir_rows.push_back('{beat_of(OP_READ), 1'b1, result_of(0, 0, 0, 1)});
        // snapshot of an empty ring
        dir_rows.push_back('{beat_of(OP_SNAP), 1'b1, result_of(0, 0, 0, 0)});
        for (int i = 0; i < HDR_BYTES; i++)
            dir_rows.push_back('{beat_of(OP_READ), 1'b0, '0});
        dir_rows.push_back('{item_of(OP_EVENT, '1, '1, '1, '1, '1, '1), 1'b0, '0});
        dir_rows.push_back('{item_of(OP_EVENT, '0, '0, '0, '0, '0, '0), 1'b0, '0});
        dir_rows.push_back('{item_of(OP_SPARE, '1, '1, '1, '1, '1, '1), 1'b0, '0});
        dir_rows.push_back('{beat_of(OP_SNAP), 1'b1, result_of(2, 0, 0, 0)});
        // frozen: event dropped, snapshot re-latched
        dir_rows.push_back('{beat_of(OP_EVENT), 1'b0, '0});
        dir_rows.push_back('{beat_of(OP_SNAP), 1'b1, result_of(2, 0, 0, 0)});
        dir_rows.push_back('{beat_of(OP_READ), 1'b1, result_of(2, "I", 1, 0)});
        dir_rows.push_back('{beat_of(OP_READ), 1'b0, '0});

        @(posedge rst_n);
        @(negedge clk);
        foreach (dir_rows[i])
            post_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

        drain_stream();
        // short rings, full drains
        repeat (3) begin
            record_burst($urandom_range(1, 4));
            post(beat_of(OP_SNAP));
            read_bytes($urandom_range(1, 10));
            if ($urandom_range(0, 1) == 1) begin
                post(beat_of(OP_EVENT));
                post(beat_of(OP_SNAP));
            end
            drain_stream();
            read_bytes($urandom_range(1, 2));
        end
        // wrap the ring and drain a full snapshot
        n = (RING_DEPTH - int'(ring_head)) + $urandom_range(RING_DEPTH / 2, RING_DEPTH - 2);
        record_burst(n);
        post(beat_of(OP_SNAP));
        read_bytes($urandom_range(1, 20));
        drain_stream();
        read_bytes($urandom_range(1, 2));
        // full ring, mostly partial reads
        while (live_items < RANDOM_ITEMS) begin
            if (!ring_frozen) begin
                record_burst($urandom_range(1, 24));
                post(beat_of(OP_SNAP));
            end else begin
                case ($urandom_range(0, 9))
                    0: post(beat_of(OP_SNAP));
                    1: post(beat_of(OP_EVENT));
                    2: post(beat_of(OP_SPARE));
                    default: read_bytes($urandom_range(1, 40));
                endcase
            end
        end

        ev_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int        stall;
        int        res_beats;
        t_out_item want;
        t_out_item got;
        res_beats    = 0;
        res_if.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            stall = $urandom_range(0, 7);
            // long hold-off to back the block up
            if (res_beats == 40 || res_beats == 700)
                stall = HOLD_CYCLES;
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!(res_if.valid && res_if.ready));
            got = res_if.data;
            res_beats++;
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: record_count %0d data_byte %0h",
                       got.record_count, got.data_byte);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got.record_count !== want.record_count) begin
                    $error("record_count: expected %0d, got %0d",
                           want.record_count, got.record_count);
                    mismatches++;
                end
                if (got.data_byte !== want.data_byte) begin
                    $error("data_byte: expected %0h, got %0h", want.data_byte, got.data_byte);
                    mismatches++;
                end
                if (got.byte_valid !== want.byte_valid) begin
                    $error("byte_valid: expected %0b, got %0b",
                           want.byte_valid, got.byte_valid);
                    mismatches++;
                end
                if (got.drained !== want.drained) begin
                    $error("drained: expected %0b, got %0b", want.drained, got.drained);
                    mismatches++;
                end
            end
            @(negedge clk);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((ev_if.valid && ev_if.ready) || (res_if.valid && res_if.ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

endmodule
